FILE: hw/rtl/tts_pkg.sv
package tts_pkg;

  localparam int SLOTS_DEF = 8;

  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_LOAD = 2'd1;
  localparam logic [1:0] KIND_TAKE = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  slot;
    logic [15:0] first_delay;
    logic [15:0] repeat_period;
    logic        present;
  } tts_in_t;

  typedef struct packed {
    logic [7:0] due_mask;
    logic [7:0] pending_runs;
    logic       slot_filled;
  } tts_out_t;

  // One row of the task table.
  typedef struct packed {
    logic        present;
    logic [15:0] delay;
    logic [15:0] period;
    logic [7:0]  run_count;
  } tts_entry_t;

endpackage

FILE: hw/rtl/tts_table.sv
module tts_table
  import tts_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF,
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output tts_entry_t       rd_data,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  tts_entry_t       wr_data
);

  tts_entry_t       mem_r [SLOTS];
  tts_entry_t       q_r;
  logic [SLOTS-1:0] vld_r;
  logic             q_vld_r;

  // Storage array; rows never written read back as all zero.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      q_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        q_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = q_vld_r ? q_r : '0;

endmodule

FILE: hw/rtl/tick_task_scheduler_table.sv
// Tick: result strobe once every slot has been walked; the next request can
//   be taken in the cycle the result is shown.
// Take: the row is read, then the result is registered. Load and unused kinds: next cycle.
// The table's single read and single write port set the tick time: one slot
//   is read, updated and written back per cycle. Sync active-low reset empties
//   the table at once; results cannot be stalled by the receiver.
module tick_task_scheduler_table
  import tts_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  tts_in_t  in_data,
  output logic     out_valid,
  output tts_out_t out_data
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_TICK = 3'b010,
    S_TAKE = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;     // slot whose row is on the read port
  logic [7:0]       mask_r, mask_nxt;   // due bits gathered during a tick
  logic             out_valid_r, out_valid_nxt;
  tts_out_t         out_data_r, out_data_nxt;

  // table ports
  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  tts_entry_t       rd_data, wr_data;

  logic             accept;
  logic             in_range;
  logic [IDX_W-1:0] req_idx;
  logic             last_slot;
  logic [6:0]       idx_ext;
  logic             due;
  logic [7:0]       due_bit;

  assign accept    = start && (state_r == S_IDLE);
  assign in_range  = 7'(in_data.slot) < 7'(SLOTS);
  assign req_idx   = IDX_W'(in_data.slot);
  assign last_slot = 7'(idx_r) == 7'(SLOTS - 1);
  assign idx_ext   = 7'(idx_r);

  // A present slot with a spent delay falls due on this tick.
  assign due = rd_data.present && (rd_data.delay == 16'd0);

  // Only the first eight slots own a bit in the result mask.
  always_comb begin
    due_bit = '0;
    for (int b = 0; b < 8; b++) begin
      if (due && (idx_ext == 7'(b))) begin
        due_bit[b] = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    mask_nxt      = mask_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    rd_en         = 1'b0;
    rd_addr       = idx_r;
    wr_en         = 1'b0;
    wr_addr       = idx_r;
    wr_data       = rd_data;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_data.kind)
            KIND_TICK: begin
              // fetch slot 0, then walk the table
              rd_en     = 1'b1;
              rd_addr   = '0;
              idx_nxt   = '0;
              mask_nxt  = '0;
              state_nxt = S_TICK;
            end
            KIND_TAKE: begin
              if (in_range) begin
                rd_en     = 1'b1;
                rd_addr   = req_idx;
                idx_nxt   = req_idx;
                state_nxt = S_TAKE;
              end else begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = '0;
              end
            end
            KIND_LOAD: begin
              // load writes straight from the request; run count restarts
              if (in_range) begin
                wr_en   = 1'b1;
                wr_addr = req_idx;
                if (in_data.present) begin
                  wr_data = '{present:   1'b1,
                              delay:     in_data.first_delay,
                              period:    in_data.repeat_period,
                              run_count: 8'd0};
                end else begin
                  wr_data = '0;
                end
              end
              out_valid_nxt = 1'b1;
              out_data_nxt  = '0;
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '0;
            end
          endcase
        end
      end

      S_TICK: begin
        // update row idx_r while the next row is fetched
        wr_en = 1'b1;
        if (due) begin
          if (rd_data.run_count != 8'hFF) begin
            wr_data.run_count = rd_data.run_count + 8'd1;
          end
          if (rd_data.period != 16'd0) begin
            wr_data.delay = rd_data.period;
          end
        end else if (rd_data.present) begin
          wr_data.delay = rd_data.delay - 16'd1;
        end
        if (last_slot) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{due_mask: mask_r | due_bit, pending_runs: 8'd0,
                            slot_filled: 1'b0};
          state_nxt     = S_IDLE;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = idx_r + IDX_W'(1);
          idx_nxt  = idx_r + IDX_W'(1);
          mask_nxt = mask_r | due_bit;
        end
      end

      S_TAKE: begin
        out_valid_nxt = 1'b1;
        if (rd_data.present) begin
          out_data_nxt = '{due_mask: 8'd0, pending_runs: rd_data.run_count,
                           slot_filled: 1'b1};
          if (rd_data.run_count != 8'd0) begin
            wr_en             = 1'b1;
            wr_data.run_count = rd_data.run_count - 8'd1;
          end
        end else begin
          out_data_nxt = '0;
        end
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    mask_r     <= mask_nxt;
    out_data_r <= out_data_nxt;
  end

  tts_table #(
    .SLOTS (SLOTS)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
